// ===== design/clbs_pkg.sv =====
// Shared types and constants for the character LCD bus sequencer.
// Used by clbs_expand, clbs_cell and char_lcd_bus_sequencer_core; no dependencies.
package clbs_pkg;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_CMD   = 2'd0,
        OP_DATA  = 2'd1,
        OP_POS   = 2'd2,
        OP_GLYPH = 2'd3
    } opcode_t;

    // Longest request: glyph in 4-bit mode, 11 bytes as 22 nibbles
    localparam int NUM_BYTES  = 11;
    localparam int NUM_CELLS  = 2 * NUM_BYTES;
    localparam int BCNT_W     = $clog2(NUM_BYTES + 1);
    localparam int SCNT_W     = $clog2(NUM_CELLS + 1);
    localparam int GLYPH_ROWS = 8;

    // DDRAM row bases and CGRAM address command
    localparam logic [7:0] ROW1_BASE  = 8'h80;
    localparam logic [7:0] ROW2_BASE  = 8'hC0;
    localparam logic [7:0] ROW3_BASE  = 8'h94;
    localparam logic [7:0] ROW4_BASE  = 8'hD4;
    localparam logic [7:0] CGRAM_BASE = 8'h40;

    localparam logic [7:0] ROW_1 = 8'd1;
    localparam logic [7:0] ROW_2 = 8'd2;
    localparam logic [7:0] ROW_3 = 8'd3;
    localparam logic [7:0] ROW_4 = 8'd4;

    // Register select levels
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // One byte of a request before it is split onto the bus
    typedef struct packed {
        logic       rs;
        logic [7:0] value;
    } lcd_byte_t;

    // One strobe word held in a cell of the output chain
    typedef struct packed {
        logic       valid;
        logic       rs;
        logic [7:0] value;
        logic       last;
    } strobe_t;

endpackage

// ===== design/clbs_expand.sv =====
// Request expander: turns one request into the full list of strobe words.
// Depends on clbs_pkg.
module clbs_expand
    import clbs_pkg::*;
(
    input  logic [1:0]  opcode,
    input  logic [7:0]  value_byte,
    input  logic [7:0]  row,
    input  logic [7:0]  column,
    input  logic [63:0] glyph_pattern,
    input  logic        bus_mode,
    output strobe_t     strobes [NUM_CELLS]
);

    lcd_byte_t          bytes [NUM_BYTES];
    logic [BCNT_W-1:0]  byte_cnt;
    logic [SCNT_W-1:0]  strobe_cnt;
    logic [SCNT_W-1:0]  last_idx;
    logic [7:0]         row_base;
    logic               cursor_ok;
    logic [7:0]         cursor_cmd;
    logic [7:0]         cgram_cmd;

    // Decode the row base; other rows send no cursor command
    always_comb
    begin
        cursor_ok = 1'b1;
        row_base  = ROW1_BASE;
        unique case (row)
            ROW_1:   row_base = ROW1_BASE;
            ROW_2:   row_base = ROW2_BASE;
            ROW_3:   row_base = ROW3_BASE;
            ROW_4:   row_base = ROW4_BASE;
            default: cursor_ok = 1'b0;
        endcase
    end

    // Cursor is base + column - 1, CGRAM address is 0x40 + 8*slot, both mod 256
    assign cursor_cmd = row_base + column + 8'hFF;
    assign cgram_cmd  = CGRAM_BASE + {value_byte[4:0], 3'b000};

    // Build the compacted byte list
    always_comb
    begin
        for (int k = 0; k < NUM_BYTES; k++)
        begin
            bytes[k] = '0;
        end
        byte_cnt = BCNT_W'(1);
        unique case (opcode_t'(opcode))
            OP_CMD:
            begin
                bytes[0] = '{rs: RS_CMD, value: value_byte};
            end
            OP_DATA:
            begin
                bytes[0] = '{rs: RS_DATA, value: value_byte};
            end
            OP_POS:
            begin
                if (cursor_ok)
                begin
                    bytes[0] = '{rs: RS_CMD, value: cursor_cmd};
                    bytes[1] = '{rs: RS_DATA, value: value_byte};
                    byte_cnt = BCNT_W'(2);
                end
                else
                begin
                    bytes[0] = '{rs: RS_DATA, value: value_byte};
                end
            end
            OP_GLYPH:
            begin
                bytes[0] = '{rs: RS_CMD, value: cgram_cmd};
                for (int k = 0; k < GLYPH_ROWS; k++)
                begin
                    bytes[k+1] = '{rs: RS_DATA, value: glyph_pattern[8*k +: 8]};
                end
                if (cursor_ok)
                begin
                    bytes[GLYPH_ROWS+1] = '{rs: RS_CMD, value: cursor_cmd};
                    bytes[GLYPH_ROWS+2] = '{rs: RS_DATA, value: value_byte};
                    byte_cnt            = BCNT_W'(GLYPH_ROWS + 3);
                end
                else
                begin
                    bytes[GLYPH_ROWS+1] = '{rs: RS_DATA, value: value_byte};
                    byte_cnt            = BCNT_W'(GLYPH_ROWS + 2);
                end
            end
            default:
            begin
                bytes[0] = '{rs: RS_CMD, value: value_byte};
            end
        endcase
    end

    // Double the count in 4-bit mode
    assign strobe_cnt = bus_mode ? {byte_cnt, 1'b0} : SCNT_W'(byte_cnt);
    assign last_idx   = strobe_cnt - SCNT_W'(1);

    // Spread bytes onto strobes: one per byte, or high then low nibble
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_strobe
        lcd_byte_t  nib_src;
        logic [7:0] nib_val;
        assign nib_src = bytes[g/2];
        assign nib_val = (g % 2 == 1) ? {4'h0, nib_src.value[3:0]}
                                      : {4'h0, nib_src.value[7:4]};
        if (g < NUM_BYTES)
        begin : g_wide
            assign strobes[g].rs    = bus_mode ? nib_src.rs : bytes[g].rs;
            assign strobes[g].value = bus_mode ? nib_val : bytes[g].value;
        end
        else
        begin : g_nib
            assign strobes[g].rs    = nib_src.rs;
            assign strobes[g].value = nib_val;
        end
        assign strobes[g].valid = SCNT_W'(g) < strobe_cnt;
        assign strobes[g].last  = SCNT_W'(g) == last_idx;
    end

endmodule

// ===== design/clbs_cell.sv =====
// One cell of the strobe chain: holds a strobe word and passes it toward the bus.
// Depends on clbs_pkg.
module clbs_cell
    import clbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    advance,
    input  strobe_t load_word,
    input  strobe_t up_word,
    output strobe_t word
);

    logic       valid_reg;
    logic       valid_next;
    logic       rs_reg;
    logic       rs_next;
    logic [7:0] value_reg;
    logic [7:0] value_next;
    logic       last_reg;
    logic       last_next;

    // Take a new request, else take the upstream word, else hold
    always_comb
    begin
        valid_next = valid_reg;
        rs_next    = rs_reg;
        value_next = value_reg;
        last_next  = last_reg;
        priority if (load)
        begin
            valid_next = load_word.valid;
            rs_next    = load_word.rs;
            value_next = load_word.value;
            last_next  = load_word.last;
        end
        else if (advance)
        begin
            valid_next = up_word.valid;
            rs_next    = up_word.rs;
            value_next = up_word.value;
            last_next  = up_word.last;
        end
    end

    // Valid bit clears on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        rs_reg    <= rs_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign word = '{valid: valid_reg, rs: rs_reg, value: value_reg, last: last_reg};

endmodule

// ===== design/char_lcd_bus_sequencer_core.sv =====
// Top level of the character LCD bus sequencer: config register, expander, strobe chain.
// Depends on clbs_pkg, clbs_expand and clbs_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request word: opcode, value_byte,
//   row, column, glyph_pattern. Output channel (out_valid/out_ready) carries one word
//   per enable strobe: reg_select, bus_value and last_strobe on the final strobe.
//   cfg_write/cfg_data set bus_mode (0: 8-bit bus, 1: 4-bit bus); write only when idle.
// Flow:
//   A request is expanded combinationally into a row of 22 cells; its first strobe
//   shows on the outputs the cycle after acceptance. The chain moves one cell per
//   cycle while out_ready is high or the head cell is empty. The next request is
//   accepted in the cycle its predecessor's final strobe is taken, so strobes flow
//   with no gap between requests.
// Reset:
//   rst_n clears every cell's valid bit and sets bus_mode to 8-bit.
// Stall:
//   While out_ready is low and a strobe is waiting, the chain holds and in_ready
//   stays low; a new request is taken only into an empty chain or in the cycle
//   the final strobe of the current one is taken.
module char_lcd_bus_sequencer_core
    import clbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  value_byte,
    input  logic [7:0]  row,
    input  logic [7:0]  column,
    input  logic [63:0] glyph_pattern,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        reg_select,
    output logic [7:0]  bus_value,
    output logic        last_strobe
);

    logic                 bus_mode_reg;
    logic                 bus_mode_next;
    strobe_t              load_words [NUM_CELLS];
    strobe_t              cells      [NUM_CELLS];
    logic                 advance;
    logic                 in_fire;
    logic [NUM_CELLS-1:0] valid_vec;
    logic [NUM_CELLS-1:0] last_vec;

    // Bus mode register
    assign bus_mode_next = cfg_write ? cfg_data : bus_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg <= 1'b0;
        end
        else
        begin
            bus_mode_reg <= bus_mode_next;
        end
    end

    // Expand the incoming request
    clbs_expand u_expand (
        .opcode        (opcode),
        .value_byte    (value_byte),
        .row           (row),
        .column        (column),
        .glyph_pattern (glyph_pattern),
        .bus_mode      (bus_mode_reg),
        .strobes       (load_words)
    );

    // Advance when the head word leaves or the head is empty
    assign advance  = out_ready || !cells[0].valid;
    assign in_ready = !cells[1].valid && advance;
    assign in_fire  = in_valid && in_ready;

    // Chain of cells, head cell drives the bus
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        strobe_t up_word;
        if (g == NUM_CELLS - 1)
        begin : g_tail
            assign up_word = '0;
        end
        else
        begin : g_mid
            assign up_word = cells[g+1];
        end

        clbs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (in_fire),
            .advance   (advance),
            .load_word (load_words[g]),
            .up_word   (up_word),
            .word      (cells[g])
        );

        assign valid_vec[g] = cells[g].valid;
        assign last_vec[g]  = cells[g].last;
    end

    assign out_valid   = cells[0].valid;
    assign reg_select  = cells[0].rs;
    assign bus_value   = cells[0].value;
    assign last_strobe = cells[0].last;

`ifndef SYNTH
    // An accepted request shows its first strobe next cycle
    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("accepted request produced no strobe");

    // Occupied cells form a solid run from the head
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + NUM_CELLS'(1))) == '0)
        else $error("gap in strobe chain");

    // Exactly one final strobe in a busy chain
    a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
        (|valid_vec) |-> $countones(valid_vec & last_vec) == 1)
        else $error("chain must hold exactly one final strobe");

    // Nibble mode keeps the upper data lines low
    a_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        (bus_mode_reg && out_valid && $past(bus_mode_reg) && $past(in_fire))
        |-> bus_value[7:4] == 4'h0)
        else $error("upper lines driven in 4-bit mode");
`endif

endmodule
